/* rtl/liv_pkg.sv */
// Package for the Lehmer-seeded key/IV derivation block.
// Holds the generator constants and the pipeline payload types.
// No dependencies.
package liv_pkg;

  localparam logic [31:0] SeedOffset = 32'd23456911;
  localparam logic [31:0] LcgMul     = 32'd16807;
  localparam logic [31:0] LcgMod     = 32'h7fffffff;
  localparam int unsigned QuotShift  = 49;
  localparam logic [32:0] QuotRecip  = 33'((64'd1 << QuotShift) / 64'd127773 + 64'd1);
  localparam int unsigned QuotW      = 15;
  localparam int unsigned NumWords   = 4;

  typedef struct packed {
    logic [NumWords-2:0][31:0] w;
    logic [31:0]               s;
  } lane_t;

  typedef struct packed {
    logic [NumWords-2:0][31:0] w;
    logic [31:0]               p;
    logic [QuotW-1:0]          q;
    logic                      neg;
  } step_a_t;

endpackage

/* rtl/liv_if.sv */
// Handshake channels for the key/IV derivation block.
// Depends on nothing; one interface for indexes, one for results.
interface liv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] item_index;

  modport source (output valid, output item_index, input ready);
  modport sink (input valid, input item_index, output ready);
endinterface

interface liv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] word3;

  modport source (output valid, output word0, output word1, output word2, output word3,
                  input ready);
  modport sink (input valid, input word0, input word1, input word2, input word3,
                output ready);
endinterface

/* rtl/liv_seed.sv */
// Seed stage: adds the fixed offset to the index and, in beta mode, halves a seed whose top bit is set.
// Depends on liv_pkg.
module liv_seed import liv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] index_i,
  input  logic        beta_i,
  output logic        valid_o,
  output lane_t       lane_o
);

  logic        valid_q;
  lane_t       lane_q;
  lane_t       lane_d;
  logic [31:0] seed;

  always_comb begin
    seed = index_i + SeedOffset;
    if (beta_i && seed[31]) begin
      seed = {1'b0, seed[31:1]};
    end
    lane_d   = '0;
    lane_d.s = seed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

/* rtl/liv_step.sv */
// One Park-Miller step in two register stages, Schrage form with wrap.
// The first stage also stores the negated incoming value into each result word whose word_we_i bit is set.
// Depends on liv_pkg.
module liv_step import liv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  lane_t               lane_i,
  input  logic [NumWords-2:0] word_we_i,
  output logic                valid_o,
  output lane_t               lane_o
);

  logic        a_valid_q;
  step_a_t     a_q;
  step_a_t     a_d;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [31:0] mul_lo;

  logic        b_valid_q;
  lane_t       b_q;
  lane_t       b_d;
  logic [31:0] q_ext;
  logic [31:0] q_sgn;
  logic [31:0] v;

  // Stage A: magnitude divided by 127773 through an exact reciprocal, and s * 16807.
  always_comb begin
    mag    = lane_i.s[31] ? 32'(32'd0 - lane_i.s) : lane_i.s;
    prod   = 64'({32'd0, mag} * {31'd0, QuotRecip});
    mul_lo = 32'(lane_i.s * LcgMul);
    a_d.w  = lane_i.w;
    for (int j = 0; j < NumWords - 1; j++) begin
      if (word_we_i[j]) begin
        a_d.w[j] = 32'd0 - lane_i.s;
      end
    end
    a_d.p   = mul_lo;
    a_d.q   = prod[QuotShift+QuotW-1:QuotShift];
    a_d.neg = lane_i.s[31];
  end

  // Stage B: s*16807 - q*(2^31-1) taken modulo 2^32, then the negative fix-up.
  always_comb begin
    q_ext = {{(32 - QuotW){1'b0}}, a_q.q};
    q_sgn = a_q.neg ? 32'(32'd0 - q_ext) : q_ext;
    v     = a_q.p + q_sgn + {q_sgn[0], 31'd0};
    if (v[31]) begin
      v = v + LcgMod;
    end
    b_d.w = a_q.w;
    b_d.s = v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign lane_o  = b_q;

endmodule

/* rtl/lehmer_seeded_iv_derivation.sv */
// Top level of the Lehmer-seeded key/IV derivation pipeline.
// Depends on liv_pkg, liv_if, liv_seed and liv_step.
//
//   Channel   Direction  Carries
//   in_i      sink       item_index
//   out_o     source     word0, word1, word2, word3
//   cfg       write      cfg_we_i, cfg_data_i (beta_mode)
//
// One item enters per cycle while the pipeline is not frozen by a held result.
// The pipeline is one seed stage, five two-stage generator steps and an output register.
// Each generator step holds two multipliers in its first stage.
// A result held while out_o.ready is low freezes the whole pipeline and lowers in_i.ready.
// Reset clears all valid bits and the beta_mode register.
module lehmer_seeded_iv_derivation import liv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  liv_in_if.sink       in_i,
  liv_out_if.source    out_o,
  input  logic         cfg_we_i,
  input  logic         cfg_data_i
);

  localparam int unsigned NumSteps = 5;

  logic                       beta_q;
  logic                       en;
  logic [NumSteps:0]          valid;
  lane_t [NumSteps:0]         lane;
  logic [NumSteps-1:0][NumWords-2:0] word_we;

  logic                       out_valid_q;
  logic [NumWords-1:0][31:0]  out_q;
  logic [NumWords-1:0][31:0]  out_d;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= 1'b0;
    end else if (cfg_we_i) begin
      beta_q <= cfg_data_i;
    end
  end

  liv_seed u_seed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .index_i (in_i.item_index),
    .beta_i  (beta_q),
    .valid_o (valid[0]),
    .lane_o  (lane[0])
  );

  // The first two steps store nothing; each later step stores the word of the step before it.
  always_comb begin
    word_we = '0;
    for (int k = 2; k < NumSteps; k++) begin
      word_we[k][k-2] = 1'b1;
    end
  end

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    liv_step u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (valid[k]),
      .lane_i    (lane[k]),
      .word_we_i (word_we[k]),
      .valid_o   (valid[k+1]),
      .lane_o    (lane[k+1])
    );
  end

  always_comb begin
    for (int j = 0; j < NumWords - 1; j++) begin
      out_d[j] = lane[NumSteps].w[j];
    end
    out_d[NumWords-1] = 32'd0 - lane[NumSteps].s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.word0 = out_q[0];
  assign out_o.word1 = out_q[1];
  assign out_o.word2 = out_q[2];
  assign out_o.word3 = out_q[3];

endmodule

/* rtl/liv_checker.sv */
// Port-level checks for the key/IV derivation block, bound to its top level.
// Depends on lehmer_seeded_iv_derivation.
module liv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // With no result waiting, the pipeline always takes a new item.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // A consumer that takes results never stalls the input side.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output drains");

endmodule

bind lehmer_seeded_iv_derivation liv_checker u_liv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
